>>> sv/p2a_pkg.sv
package p2a_pkg;

	// table sizes, powers of two
	localparam int LOG_TABLE_ENTRIES = 256;
	localparam int EXP_TABLE_ENTRIES = 256;
	localparam int LOG_IDX_BITS = $clog2(LOG_TABLE_ENTRIES);
	localparam int EXP_IDX_BITS = $clog2(EXP_TABLE_ENTRIES);

	localparam logic [18:0] P_MIN = 19'd256;
	localparam logic [18:0] P_MAX = 19'd281600;
	localparam logic [18:0] P_TROPO = 19'd57938;
	localparam logic [27:0] K_LAPSE_Q8 = 28'd181578834;
	localparam logic [24:0] K_ISO_Q8 = 25'd18004689;
	localparam logic [27:0] EXPONENT_Q30 = 28'd204293555;
	localparam logic [20:0] Z_TROPO_16 = 21'd176000;

	typedef logic [30:0] log_rom_t [LOG_TABLE_ENTRIES+1];
	typedef logic [31:0] exp_rom_t [EXP_TABLE_ENTRIES+1];

	// fractional log2 of a mantissa in [2^30, 2^31), q30, by repeated squaring
	function automatic logic [63:0] frac_log2_c(input logic [63:0] m);
		logic [63:0] y;
		logic [63:0] res;
		y = m;
		res = '0;
		for (int k = 1; k <= 30; k++) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				res = res | (64'd1 << (30 - k));
			end
		end
		return res;
	endfunction

	function automatic logic [63:0] int_log2_c(input logic [63:0] n);
		int e;
		logic [63:0] m;
		e = 0;
		while (e < 63 && (n >> (e + 1)) != 0)
			e++;
		if (e <= 30)
			m = n << (30 - e);
		else
			m = n >> (e - 30);
		return (64'(e) << 30) + frac_log2_c(m);
	endfunction

	function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic log_rom_t gen_log_rom();
		log_rom_t t;
		logic [63:0] a;
		for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
			if (i >= LOG_TABLE_ENTRIES) begin
				t[i] = 31'd1 << 30;
			end else begin
				a = (64'(i) << 30) / LOG_TABLE_ENTRIES;
				t[i] = 31'(frac_log2_c((64'd1 << 30) + a));
			end
		end
		return t;
	endfunction

	function automatic exp_rom_t gen_exp_rom();
		exp_rom_t t;
		logic [63:0] roots [31];
		logic [63:0] r;
		logic [63:0] y;
		logic [63:0] f;
		r = 64'd1 << 31;
		roots[0] = r;
		for (int k = 1; k <= 30; k++) begin
			r = isqrt_c(r << 30);
			roots[k] = r;
		end
		for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
			if (i >= EXP_TABLE_ENTRIES) begin
				t[i] = 32'd1 << 31;
			end else begin
				f = (64'(i) << 30) / EXP_TABLE_ENTRIES;
				y = 64'd1 << 30;
				for (int k = 1; k <= 30; k++) begin
					if (f[30 - k])
						y = (y * roots[k]) >> 30;
				end
				t[i] = 32'(y);
			end
		end
		return t;
	endfunction

	localparam log_rom_t LOG_ROM = gen_log_rom();
	localparam exp_rom_t EXP_ROM = gen_exp_rom();

	// log2(1013.25) and log2(226.3206), q30
	localparam logic [63:0] L_REF_64 = int_log2_c(64'd4053) - (64'd2 << 30);
	localparam logic [63:0] L_TROPO_64 = int_log2_c(64'd2263206) - int_log2_c(64'd10000);
	localparam logic [34:0] L_REF = L_REF_64[34:0];
	localparam logic [34:0] L_TROPO = L_TROPO_64[34:0];

endpackage

>>> sv/p2a_log2.sv
module p2a_log2 (
	input  logic        clk,
	input  logic [18:0] p,
	output logic [33:0] lp
);
	import p2a_pkg::*;

	logic [4:0] e;
	logic [18:0] norm;
	logic [4:0] e_s2;
	logic [17:0] frac_s2;
	logic [29:0] f30;
	logic [LOG_IDX_BITS:0] idx_lo;
	logic [LOG_IDX_BITS:0] idx_hi;
	logic [30:0] lo_c;
	logic [30:0] hi_c;
	logic [30:0] lo_s3;
	logic [30:0] d_s3;
	logic [29:0] r_s3;
	logic [4:0] e_s3;
	logic [60:0] prod;
	logic [30:0] pr_s4;
	logic [30:0] lo_s4;
	logic [4:0] e_s4;
	logic [33:0] lp_s5;

	// leading one position, then left-align so the msb sits at bit 18
	always_comb begin
		e = '0;
		for (int b = 0; b < 19; b++)
			if (p[b])
				e = 5'(b);
		norm = p << (5'd18 - e);
	end

	always_comb begin
		f30 = {frac_s2, 12'b0};
		idx_lo = {1'b0, f30[29 -: LOG_IDX_BITS]};
		idx_hi = idx_lo + 1'b1;
		lo_c = LOG_ROM[idx_lo];
		hi_c = LOG_ROM[idx_hi];
		prod = 61'(d_s3) * 61'(r_s3);
	end

	always_ff @(posedge clk) begin
		e_s2 <= e;
		frac_s2 <= norm[17:0];
		lo_s3 <= lo_c;
		d_s3 <= hi_c - lo_c;
		r_s3 <= 30'(f30 << LOG_IDX_BITS);
		e_s3 <= e_s2;
		pr_s4 <= prod[60:30];
		lo_s4 <= lo_s3;
		e_s4 <= e_s3;
		lp_s5 <= ({30'b0, 4'(e_s4 - 5'd8)} << 30) + 34'(lo_s4) + 34'(pr_s4);
	end

	assign lp = lp_s5;

endmodule

>>> sv/p2a_exp2.sv
module p2a_exp2 (
	input  logic        clk,
	input  logic [31:0] t,
	output logic [33:0] y
);
	import p2a_pkg::*;

	logic [EXP_IDX_BITS:0] idx_lo;
	logic [EXP_IDX_BITS:0] idx_hi;
	logic [31:0] lo_c;
	logic [31:0] hi_c;
	logic [31:0] lo_s7;
	logic [30:0] d_s7;
	logic [29:0] r_s7;
	logic [1:0] k_s7;
	logic [60:0] prod;
	logic [30:0] pr_s8;
	logic [31:0] lo_s8;
	logic [1:0] k_s8;
	logic [32:0] sum;
	logic [33:0] ys;
	logic [33:0] y_s9;

	always_comb begin
		idx_lo = {1'b0, t[29 -: EXP_IDX_BITS]};
		idx_hi = idx_lo + 1'b1;
		lo_c = EXP_ROM[idx_lo];
		hi_c = EXP_ROM[idx_hi];
		prod = 61'(d_s7) * 61'(r_s7);
		sum = {1'b0, lo_s8} + {2'b0, pr_s8};
		// integer part of the exponent, floor, in -2..1
		case (k_s8)
			2'b01: ys = {sum, 1'b0};
			2'b00: ys = {1'b0, sum};
			2'b11: ys = {2'b0, sum[32:1]};
			default: ys = {3'b0, sum[32:2]};
		endcase
	end

	always_ff @(posedge clk) begin
		lo_s7 <= lo_c;
		d_s7 <= 31'(hi_c - lo_c);
		r_s7 <= 30'(t[29:0] << EXP_IDX_BITS);
		k_s7 <= t[31:30];
		pr_s8 <= prod[60:30];
		lo_s8 <= lo_s7;
		k_s8 <= k_s7;
		y_s9 <= ys;
	end

	assign y = y_s9;

endmodule

>>> sv/pressure_to_altitude_std_atmosphere_unit.sv
// Pressure altitude from static pressure, standard atmosphere.
// Request: drive pressure (unsigned, 1/256 hPa) and pulse start; a request is
// taken at any rising edge with start high and busy low. busy is always low,
// so a new request may be given every cycle.
// Result: done is high for exactly one cycle with altitude (signed, 1/16 m)
// and clamped; the receiver must take it then, it cannot stall the block.
// Throughput is one result per cycle, set by the 11-stage pipeline: clamp,
// log2 normalize and table interpolation (4 stages), exponent scaling,
// exp2 table interpolation (3 stages), final coefficient multiply, rounding.
// Pressure below 1 hPa or above 1100 hPa is clamped and flagged.
// Reset clears all valid bits; requests in flight are dropped and no result
// follows for them.
module pressure_to_altitude_std_atmosphere_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [18:0] pressure,
	output logic        done,
	output logic [20:0] altitude,
	output logic        clamped
);
	import p2a_pkg::*;

	typedef struct packed {
		logic valid;
		logic clamped;
		logic lapse;
	} meta_t;

	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	meta_t meta_s7, meta_s8, meta_s9, meta_s10, meta_s11;

	logic [18:0] p_s1;
	logic [33:0] lp_s5;
	logic [34:0] diff_l;
	logic signed [62:0] t_prod;
	logic [31:0] t_s6;
	logic [34:0] iso_d_s6;
	logic signed [60:0] iso_p_s7;
	logic signed [60:0] iso_r;
	logic [20:0] iso_alt_s8;
	logic [20:0] iso_alt_s9;
	logic [20:0] iso_alt_s10;
	logic [33:0] y_s9;
	logic [34:0] dl;
	logic signed [58:0] lap_p_s10;
	logic signed [58:0] lap_r;
	logic [20:0] altitude_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
			meta_s6 <= '0;
			meta_s7 <= '0;
			meta_s8 <= '0;
			meta_s9 <= '0;
			meta_s10 <= '0;
			meta_s11 <= '0;
		end else begin
			meta_s1.valid <= start;
			meta_s1.clamped <= (pressure < P_MIN) || (pressure > P_MAX);
			// the clamp never moves a pressure across the tropopause
			meta_s1.lapse <= pressure > P_TROPO;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;
			meta_s8 <= meta_s7;
			meta_s9 <= meta_s8;
			meta_s10 <= meta_s9;
			meta_s11 <= meta_s10;
		end
	end

	p2a_log2 u_log2 (
		.clk (clk),
		.p   (p_s1),
		.lp  (lp_s5)
	);

	p2a_exp2 u_exp2 (
		.clk (clk),
		.t   (t_s6),
		.y   (y_s9)
	);

	always_comb begin
		diff_l = {1'b0, lp_s5} - L_REF;
		t_prod = $signed(diff_l[33:0]) * $signed({1'b0, EXPONENT_Q30});
		iso_r = iso_p_s7 + (61'sd1 <<< 37);
		dl = (35'd1 << 30) - {1'b0, y_s9};
		lap_r = lap_p_s10 + (59'sd1 <<< 37);
	end

	always_ff @(posedge clk) begin
		if (pressure < P_MIN)
			p_s1 <= P_MIN;
		else if (pressure > P_MAX)
			p_s1 <= P_MAX;
		else
			p_s1 <= pressure;
		t_s6 <= t_prod[61:30];
		iso_d_s6 <= L_TROPO - {1'b0, lp_s5};
		iso_p_s7 <= $signed(iso_d_s6) * $signed({1'b0, K_ISO_Q8});
		iso_alt_s8 <= iso_r[58:38] + Z_TROPO_16;
		iso_alt_s9 <= iso_alt_s8;
		iso_alt_s10 <= iso_alt_s9;
		lap_p_s10 <= $signed(dl[29:0]) * $signed({1'b0, K_LAPSE_Q8});
		altitude_s11 <= meta_s10.lapse ? lap_r[58:38] : iso_alt_s10;
	end

	assign busy = 1'b0;
	assign done = meta_s11.valid;
	assign altitude = altitude_s11;
	assign clamped = meta_s11.clamped;

endmodule

>>> dv/pressure_to_altitude_std_atmosphere_unit_tb.sv
`timescale 1ns / 100ps

module pressure_to_altitude_std_atmosphere_unit_tb;
	import p2a_pkg::*;

	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam longint MASK_Q30 = ONE_Q30 - 1;
	localparam int N_RANDOM = 930;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [20:0] altitude;
		logic        clamped;
	} altitude_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [18:0] pressure = '0;
	logic        busy;
	logic        done;
	logic [20:0] altitude;
	logic        clamped;

	logic [18:0] pending_q[$];
	altitude_t   altitude_q[$];
	longint      log_tbl [LOG_TABLE_ENTRIES+1];
	longint      exp_tbl [EXP_TABLE_ENTRIES+1];
	longint      log2_ref;
	longint      log2_tropo;
	int          n_errors = 0;
	int          n_sent = 0;
	int          gap = 0;
	int          stall_cnt = 0;
	bit          draining = 1'b0;
	bit          drained_once = 1'b0;
	bit          feed_done = 1'b0;

	pressure_to_altitude_std_atmosphere_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pressure(pressure),
		.done(done),
		.altitude(altitude),
		.clamped(clamped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int top_bit(longint unsigned n);
		int e;
		e = 0;
		while (e < 63 && (n >> (e + 1)) != 0)
			e++;
		return e;
	endfunction

	// mantissa in [2^30, 2^31), bit-serial fractional log2
	function automatic longint mant_log2(longint unsigned m);
		longint unsigned y;
		longint unsigned acc;
		y = m;
		acc = 0;
		for (int k = 1; k <= 30; k++) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				acc = acc | (64'd1 << (30 - k));
			end
		end
		return longint'(acc);
	endfunction

	function automatic longint exact_log2(longint unsigned n);
		int e;
		longint unsigned m;
		e = top_bit(n);
		m = (e <= 30) ? (n << (30 - e)) : (n >> (e - 30));
		return (longint'(e) << 30) + mant_log2(m);
	endfunction

	function automatic longint unsigned sqrt_floor(longint unsigned v_in);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic build_tables();
		longint unsigned f;
		longint unsigned y;
		longint unsigned rt;
		for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
			if (i == LOG_TABLE_ENTRIES)
				log_tbl[i] = ONE_Q30;
			else
				log_tbl[i] = mant_log2((64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES));
		end
		for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
			if (i == EXP_TABLE_ENTRIES) begin
				exp_tbl[i] = 64'sd1 << 31;
			end else begin
				f = (64'(i) << 30) / EXP_TABLE_ENTRIES;
				y = 64'd1 << 30;
				rt = 64'd1 << 31;
				for (int k = 1; k <= 30; k++) begin
					rt = sqrt_floor(rt << 30);
					if ((f >> (30 - k)) & 1)
						y = (y * rt) >> 30;
				end
				exp_tbl[i] = longint'(y);
			end
		end
		log2_ref = exact_log2(4053) - 2 * ONE_Q30;
		log2_tropo = exact_log2(2263206) - exact_log2(10000);
	endtask

	function automatic altitude_t predict_altitude(logic [18:0] p_in);
		altitude_t res;
		longint unsigned p;
		longint unsigned pos;
		longint lp;
		longint t;
		longint k;
		longint y;
		longint lo;
		longint hi;
		longint alt;
		longint r;
		int e;
		int i;
		p = p_in;
		res.clamped = 1'b0;
		if (p < P_MIN) begin
			p = P_MIN;
			res.clamped = 1'b1;
		end else if (p > P_MAX) begin
			p = P_MAX;
			res.clamped = 1'b1;
		end
		e = top_bit(p);
		pos = ((p << (30 - e)) & MASK_Q30) * LOG_TABLE_ENTRIES;
		i = int'(pos >> 30);
		r = longint'(pos & MASK_Q30);
		lo = log_tbl[i];
		hi = log_tbl[i+1];
		lp = (longint'(e) - 8) * ONE_Q30 + lo + (((hi - lo) * r) >>> 30);
		if (p > P_TROPO) begin
			t = ((lp - log2_ref) * longint'(EXPONENT_Q30)) >>> 30;
			k = t >>> 30;
			pos = longint'((t - k * ONE_Q30) & MASK_Q30) * EXP_TABLE_ENTRIES;
			i = int'(pos >> 30);
			r = longint'(pos & MASK_Q30);
			lo = exp_tbl[i];
			hi = exp_tbl[i+1];
			y = lo + (((hi - lo) * r) >>> 30);
			if (k > 30)
				k = 30;
			if (k < -31)
				k = -31;
			y = (k >= 0) ? (y << k) : longint'(longint'(unsigned'(y)) >> (-k));
			alt = (longint'(K_LAPSE_Q8) * (ONE_Q30 - y) + (64'sd1 << 37)) >>> 38;
		end else begin
			alt = longint'(Z_TROPO_16)
				+ ((longint'(K_ISO_Q8) * (log2_tropo - lp) + (64'sd1 << 37)) >>> 38);
		end
		res.altitude = alt[20:0];
		return res;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			pressure <= '0;
		end else begin
			if (start && !busy) begin
				altitude_q.push_back(predict_altitude(pressure));
				n_sent++;
				if (n_sent == 400 && !drained_once)
					draining = 1'b1;
			end
			if (!start || !busy) begin
				if (draining && (altitude_q.size() != 0 || start)) begin
					start <= 1'b0;
				end else if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (pending_q.size() != 0) begin
					if (draining) begin
						draining = 1'b0;
						drained_once = 1'b1;
					end
					start <= 1'b1;
					pressure <= pending_q.pop_front();
					// no idling near the end of the run
					if (pending_q.size() > 150 && $urandom_range(0, 7) == 0)
						gap = $urandom_range(1, 13);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		altitude_t want;
		if (arst_n && done) begin
			if (altitude_q.size() == 0) begin
				$error("unexpected result: altitude %0d clamped %0b",
					$signed(altitude), clamped);
				n_errors++;
			end else begin
				want = altitude_q.pop_front();
				if (altitude !== want.altitude) begin
					$error("altitude: expected %0d got %0d",
						$signed(want.altitude), $signed(altitude));
					n_errors++;
				end
				if (clamped !== want.clamped) begin
					$error("clamped: expected %0b got %0b", want.clamped, clamped);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [18:0] directed [] = '{19'd0, 19'd1, 19'd255, 19'd256, 19'd257,
			19'd1000, 19'd57937, 19'd57938, 19'd57939, 19'd100000, 19'd259392,
			19'd281599, 19'd281600, 19'd281601, 19'd300000, 19'h55555, 19'h2AAAA,
			19'h7FFFF};
		int sel;
		build_tables();
		foreach (directed[j])
			pending_q.push_back(directed[j]);
		for (int j = 0; j < N_RANDOM; j++) begin
			sel = $urandom_range(0, 9);
			if (sel < 7)
				pending_q.push_back(19'($urandom_range(256, 281600)));
			else if (sel == 7)
				pending_q.push_back(19'($urandom_range(57900, 57980)));
			else if (sel == 8)
				pending_q.push_back(19'($urandom));
			else
				pending_q.push_back(19'($urandom_range(0, 300)));
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (pending_q.size() != 0 || start || altitude_q.size() != 0);
		repeat (30) @(posedge clk);
		if (n_errors == 0 && altitude_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
